/* sv/tem_pkg.sv */
// Shared types and codes for the timer expiry min-heap.
package tem_pkg;

  localparam int ID_FIELD_W   = 16;
  localparam int TIME_FIELD_W = 32;
  localparam int LIVE_W       = 6;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NOMATCH = 2'd2;

  typedef struct packed {
    logic [1:0]              op;
    logic [ID_FIELD_W-1:0]   timer_id;
    logic [TIME_FIELD_W-1:0] expire_time;
    logic [TIME_FIELD_W-1:0] now;
  } tem_req_t;

  typedef struct packed {
    logic [ID_FIELD_W-1:0] fired_id;
    logic                  fired;
    logic [1:0]            status;
    logic                  last;
    logic [LIVE_W-1:0]     live_count;
  } tem_rsp_t;

  // Events from the heap sequencer to the request/response front end.
  typedef struct packed {
    logic       push;
    logic       done;
    logic [1:0] status;
  } tem_evt_t;

endpackage

/* sv/tem_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module tem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/tem_heap_seq.sv */
// Heap sequencer: add, cancel, compaction, rebuild and tick over the entry RAM.
module tem_heap_seq import tem_pkg::*; #(
  parameter int CAPACITY   = 32,
  parameter int ID_WIDTH   = 16,
  parameter int TIME_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [1:0]                       op,
  input  logic [ID_WIDTH-1:0]              id,
  input  logic [TIME_WIDTH-1:0]            exp_time,
  input  logic [TIME_WIDTH-1:0]            now,
  output tem_evt_t                         evt,
  output logic [ID_WIDTH-1:0]              push_id,
  output logic [$clog2(CAPACITY+1)-1:0]    size
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = 1 + ID_WIDTH + TIME_WIDTH;
  localparam int VB = EW - 1;

  typedef enum logic [16:0] {
    S_IDLE   = 17'b00000000000000001,
    S_UP_RD  = 17'b00000000000000010,
    S_UP_CMP = 17'b00000000000000100,
    S_DN_LD  = 17'b00000000000001000,
    S_DN_L   = 17'b00000000000010000,
    S_DN_R   = 17'b00000000000100000,
    S_DN_CMP = 17'b00000000001000000,
    S_CN_RD  = 17'b00000000010000000,
    S_CN_CHK = 17'b00000000100000000,
    S_CN_END = 17'b00000001000000000,
    S_CP_RD  = 17'b00000010000000000,
    S_CP_CHK = 17'b00000100000000000,
    S_RB     = 17'b00001000000000000,
    S_TK_RD  = 17'b00010000000000000,
    S_TK_CHK = 17'b00100000000000000,
    S_DONE   = 17'b01000000000000000,
    S_SPARE  = 17'b10000000000000000
  } state_t;

  state_t state, state_next;
  logic [CW-1:0] size_next, cc, cc_next;
  logic [CW-1:0] i, i_next, k, k_next, scan, scan_next, w, w_next, hits, hits_next;
  logic [EW-1:0] cur, cur_next, lch, lch_next;
  logic has_r, has_r_next, ret_tick, ret_tick_next;
  logic [1:0] status, status_next;
  logic [ID_WIDTH-1:0] id_r, id_r_next;
  logic [TIME_WIDTH-1:0] now_r, now_r_next;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;
  logic push;

  logic [CW:0] lidx;
  logic [CW-1:0] parent;
  logic [CW-1:0] cc_sum;
  logic [EW-1:0] cand;
  logic [CW-1:0] cidx;

  tem_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_entries (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign lidx   = {i, 1'b1};
  assign parent = (i - CW'(1)) >> 1;
  assign cc_sum = cc + hits;

  always_comb begin
    state_next    = state;
    size_next     = size;
    cc_next       = cc;
    i_next        = i;
    k_next        = k;
    scan_next     = scan;
    w_next        = w;
    hits_next     = hits;
    cur_next      = cur;
    lch_next      = lch;
    has_r_next    = has_r;
    ret_tick_next = ret_tick;
    status_next   = status;
    id_r_next     = id_r;
    now_r_next    = now_r;
    we            = 1'b0;
    waddr         = AW'(i);
    wdata         = cur;
    raddr         = '0;
    push          = 1'b0;
    cand          = lch;
    cidx          = CW'(lidx);

    case (state)
      S_IDLE: begin
        if (start) begin
          id_r_next   = id;
          now_r_next  = now;
          status_next = ST_OK;
          case (op)
            OP_ADD: begin
              if (size >= CW'(CAPACITY)) begin
                status_next = ST_FULL;
                state_next  = S_DONE;
              end else begin
                cur_next   = {1'b1, id, exp_time};
                i_next     = size;
                size_next  = size + CW'(1);
                state_next = S_UP_RD;
              end
            end
            OP_CANCEL: begin
              scan_next  = '0;
              hits_next  = '0;
              state_next = S_CN_RD;
            end
            OP_TICK:  state_next = S_TK_RD;
            default:  state_next = S_DONE;
          endcase
        end
      end

      // Sift-up moves a hole toward the root instead of swapping.
      S_UP_RD: begin
        if (i == '0) begin
          we         = 1'b1;
          state_next = S_DONE;
        end else begin
          raddr      = AW'(parent);
          state_next = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        we = 1'b1;
        if (cur[TIME_WIDTH-1:0] < rdata[TIME_WIDTH-1:0]) begin
          wdata      = rdata;
          i_next     = parent;
          state_next = S_UP_RD;
        end else begin
          state_next = S_DONE;
        end
      end

      S_DN_LD: begin
        cur_next   = rdata;
        state_next = S_DN_L;
      end

      S_DN_L: begin
        if (lidx >= {1'b0, size}) begin
          we         = 1'b1;
          state_next = ret_tick ? S_TK_RD : S_RB;
        end else begin
          raddr      = AW'(lidx);
          state_next = S_DN_R;
        end
      end

      S_DN_R: begin
        lch_next   = rdata;
        has_r_next = (lidx + (CW+1)'(1)) < {1'b0, size};
        raddr      = AW'(lidx + (CW+1)'(1));
        state_next = S_DN_CMP;
      end

      S_DN_CMP: begin
        if (has_r && (rdata[TIME_WIDTH-1:0] < lch[TIME_WIDTH-1:0])) begin
          cand = rdata;
          cidx = CW'(lidx) + CW'(1);
        end
        we = 1'b1;
        if (cand[TIME_WIDTH-1:0] < cur[TIME_WIDTH-1:0]) begin
          wdata      = cand;
          i_next     = cidx;
          state_next = S_DN_L;
        end else begin
          state_next = ret_tick ? S_TK_RD : S_RB;
        end
      end

      S_CN_RD: begin
        if (scan == size) begin
          state_next = S_CN_END;
        end else begin
          raddr      = AW'(scan);
          state_next = S_CN_CHK;
        end
      end

      S_CN_CHK: begin
        if (rdata[VB] && (rdata[TIME_WIDTH +: ID_WIDTH] == id_r)) begin
          we        = 1'b1;
          waddr     = AW'(scan);
          wdata     = {1'b0, rdata[EW-2:0]};
          hits_next = hits + CW'(1);
        end
        scan_next  = scan + CW'(1);
        state_next = S_CN_RD;
      end

      S_CN_END: begin
        if (hits == '0) begin
          status_next = ST_NOMATCH;
          state_next  = S_DONE;
        end else if (cc_sum >= (size >> 1)) begin
          scan_next  = '0;
          w_next     = '0;
          state_next = S_CP_RD;
        end else begin
          cc_next    = cc_sum;
          state_next = S_DONE;
        end
      end

      S_CP_RD: begin
        if (scan == size) begin
          size_next  = w;
          cc_next    = '0;
          k_next     = w >> 1;
          ret_tick_next = 1'b0;
          state_next = S_RB;
        end else begin
          raddr      = AW'(scan);
          state_next = S_CP_CHK;
        end
      end

      S_CP_CHK: begin
        if (rdata[VB]) begin
          we     = 1'b1;
          waddr  = AW'(w);
          wdata  = rdata;
          w_next = w + CW'(1);
        end
        scan_next  = scan + CW'(1);
        state_next = S_CP_RD;
      end

      S_RB: begin
        if (k == '0) begin
          state_next = S_DONE;
        end else begin
          raddr         = AW'(k - CW'(1));
          i_next        = k - CW'(1);
          k_next        = k - CW'(1);
          ret_tick_next = 1'b0;
          state_next    = S_DN_LD;
        end
      end

      S_TK_RD: begin
        if (size == '0) begin
          state_next = S_DONE;
        end else begin
          raddr      = '0;
          state_next = S_TK_CHK;
        end
      end

      S_TK_CHK: begin
        if (rdata[TIME_WIDTH-1:0] <= now_r) begin
          if (rdata[VB]) begin
            push = 1'b1;
          end else if (cc != '0) begin
            cc_next = cc - CW'(1);
          end
          size_next = size - CW'(1);
          if (size == CW'(1)) begin
            state_next = S_DONE;
          end else begin
            // The last slot moves to the root and sinks.
            raddr         = AW'(size - CW'(1));
            i_next        = '0;
            ret_tick_next = 1'b1;
            state_next    = S_DN_LD;
          end
        end else begin
          state_next = S_DONE;
        end
      end

      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      size  <= '0;
      cc    <= '0;
    end else begin
      state <= state_next;
      size  <= size_next;
      cc    <= cc_next;
    end
  end

  always_ff @(posedge clk) begin
    i        <= i_next;
    k        <= k_next;
    scan     <= scan_next;
    w        <= w_next;
    hits     <= hits_next;
    cur      <= cur_next;
    lch      <= lch_next;
    has_r    <= has_r_next;
    ret_tick <= ret_tick_next;
    status   <= status_next;
    id_r     <= id_r_next;
    now_r    <= now_r_next;
  end

  assign evt.push   = push;
  assign evt.done   = (state == S_DONE);
  assign evt.status = status;
  assign push_id    = rdata[TIME_WIDTH +: ID_WIDTH];

endmodule

/* sv/timer_expiry_min_heap.sv */
// Top level of the timer queue: request intake, fired-id buffer and response register.
//
//   channel | signals                    | payload
//   request | req_valid, req_ready, req  | tem_req_t: op, timer_id, expire_time, now
//   response| rsp_valid, rsp_ready, rsp  | tem_rsp_t: fired_id, fired, status, last, live_count
//
// One request is handled at a time, and every access to the entry RAM waits for registered read data.
// Add sifts the new entry up from the end. Cancel scans every held entry and, once cancelled
// entries reach half the held count, runs a compaction pass and a rebuild of every internal slot.
// Tick pops each expired entry from the root, then sends one response per fired id.
// Reset clears the control state only; no clearing pass runs. A request is taken only when the
// response register is empty or being emptied, so a stalled response holds the block.
module timer_expiry_min_heap import tem_pkg::*; #(
  parameter int CAPACITY   = 32,
  parameter int ID_WIDTH   = 16,
  parameter int TIME_WIDTH = 32
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  tem_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output tem_rsp_t rsp
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [3:0] {
    T_IDLE  = 4'b0001,
    T_BUSY  = 4'b0010,
    T_DR_RD = 4'b0100,
    T_DR_LD = 4'b1000
  } tstate_t;

  tstate_t tstate, tstate_next;
  logic [CW-1:0] wr_cnt, wr_cnt_next, rd_ptr, rd_ptr_next;
  logic rsp_valid_next;
  tem_rsp_t rsp_next;
  logic tick_r, tick_r_next;

  tem_evt_t evt;
  logic [ID_WIDTH-1:0] push_id, fifo_q;
  logic [CW-1:0] size;
  logic start, load_ok;

  assign load_ok   = !rsp_valid || rsp_ready;
  assign req_ready = (tstate == T_IDLE) && load_ok;
  assign start     = req_valid && req_ready;

  tem_heap_seq #(.CAPACITY(CAPACITY), .ID_WIDTH(ID_WIDTH), .TIME_WIDTH(TIME_WIDTH)) u_seq (
    .clk(clk), .rst(rst), .start(start), .op(req.op),
    .id(ID_WIDTH'(req.timer_id)), .exp_time(TIME_WIDTH'(req.expire_time)),
    .now(TIME_WIDTH'(req.now)), .evt(evt), .push_id(push_id), .size(size)
  );

  tem_ram #(.WIDTH(ID_WIDTH), .DEPTH(CAPACITY)) u_fired (
    .clk(clk), .we(evt.push), .waddr(AW'(wr_cnt)), .wdata(push_id),
    .raddr(AW'(rd_ptr)), .rdata(fifo_q)
  );

  always_comb begin
    tstate_next    = tstate;
    wr_cnt_next    = wr_cnt;
    rd_ptr_next    = rd_ptr;
    tick_r_next    = tick_r;
    rsp_valid_next = rsp_valid && !rsp_ready;
    rsp_next       = rsp;
    if (evt.push) begin
      wr_cnt_next = wr_cnt + CW'(1);
    end
    case (tstate)
      T_IDLE: begin
        if (start) begin
          wr_cnt_next = '0;
          rd_ptr_next = '0;
          tick_r_next = (req.op == OP_TICK);
          tstate_next = T_BUSY;
        end
      end
      T_BUSY: begin
        // The response register is free here, since a request is only taken once it is.
        if (evt.done) begin
          if (tick_r && (wr_cnt != '0)) begin
            tstate_next = T_DR_RD;
          end else begin
            rsp_valid_next      = 1'b1;
            rsp_next.fired_id   = '0;
            rsp_next.fired      = 1'b0;
            rsp_next.status     = evt.status;
            rsp_next.last       = 1'b1;
            rsp_next.live_count = LIVE_W'(size);
            tstate_next         = T_IDLE;
          end
        end
      end
      T_DR_RD: tstate_next = T_DR_LD;
      T_DR_LD: begin
        if (load_ok) begin
          rsp_valid_next      = 1'b1;
          rsp_next.fired_id   = ID_FIELD_W'(fifo_q);
          rsp_next.fired      = 1'b1;
          rsp_next.status     = ST_OK;
          rsp_next.last       = (rd_ptr + CW'(1) == wr_cnt);
          rsp_next.live_count = LIVE_W'(size);
          rd_ptr_next         = rd_ptr + CW'(1);
          tstate_next         = (rd_ptr + CW'(1) == wr_cnt) ? T_IDLE : T_DR_RD;
        end
      end
      default: tstate_next = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tstate    <= T_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      tstate    <= tstate_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    wr_cnt <= wr_cnt_next;
    rd_ptr <= rd_ptr_next;
    tick_r <= tick_r_next;
    rsp    <= rsp_next;
  end

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the timer expiry min-heap timer queue.
`timescale 1ns / 1ps

module testbench;
  import tem_pkg::*;

  localparam int CAP = 32;
  localparam int MAX_CYCLES = 2000000;

  // Scoreboard: a software heap that mirrors the timer queue and holds expected responses.
  class timer_heap_scoreboard;
    logic [31:0] expiry[CAP];
    logic [15:0] ids[CAP];
    bit          live[CAP];
    int          size;
    int          cancelled;
    tem_rsp_t    pending[$];
    int          errors;
    int          checked;
    int          fired_seen;
    int          full_seen;
    int          nomatch_seen;

    function new();
      size = 0;
      cancelled = 0;
      errors = 0;
      checked = 0;
      fired_seen = 0;
      full_seen = 0;
      nomatch_seen = 0;
      foreach (live[i]) live[i] = 0;
    endfunction

    function void swap_slots(int a, int b);
      logic [31:0] e;
      logic [15:0] d;
      bit v;
      e = expiry[a]; d = ids[a]; v = live[a];
      expiry[a] = expiry[b]; ids[a] = ids[b]; live[a] = live[b];
      expiry[b] = e; ids[b] = d; live[b] = v;
    endfunction

    function void sift_up(int i);
      int p;
      while (i > 0) begin
        p = (i - 1) / 2;
        if (expiry[i] < expiry[p]) begin
          swap_slots(i, p);
          i = p;
        end else begin
          break;
        end
      end
    endfunction

    function void sift_down(int i);
      int l;
      int c;
      forever begin
        l = 2 * i + 1;
        if (l >= size) break;
        c = l;
        if (l + 1 < size && expiry[l + 1] < expiry[l]) c = l + 1;
        if (expiry[c] < expiry[i]) begin
          swap_slots(i, c);
          i = c;
        end else begin
          break;
        end
      end
    endfunction

    function void compact();
      int w;
      w = 0;
      for (int i = 0; i < size; i++) begin
        if (live[i]) begin
          expiry[w] = expiry[i];
          ids[w] = ids[i];
          live[w] = 1;
          w++;
        end
      end
      for (int i = w; i < size; i++) live[i] = 0;
      size = w;
      cancelled = 0;
      for (int i = size / 2; i > 0; i--) sift_down(i - 1);
    endfunction

    function void pop_root();
      size--;
      if (size > 0) begin
        expiry[0] = expiry[size];
        ids[0] = ids[size];
        live[0] = live[size];
        sift_down(0);
      end
      live[size] = 0;
    endfunction

    // Works out the responses one accepted request causes.
    function void note_request(tem_req_t r);
      tem_rsp_t batch[$];
      tem_rsp_t one;
      int hits;
      one = '0;
      if (r.op == OP_ADD) begin
        if (size >= CAP) begin
          one.status = ST_FULL;
          full_seen++;
        end else begin
          expiry[size] = r.expire_time;
          ids[size] = r.timer_id;
          live[size] = 1;
          size++;
          sift_up(size - 1);
        end
        batch.push_back(one);
      end else if (r.op == OP_CANCEL) begin
        hits = 0;
        for (int i = 0; i < size; i++) begin
          if (live[i] && ids[i] == r.timer_id) begin
            live[i] = 0;
            hits++;
          end
        end
        if (hits == 0) begin
          one.status = ST_NOMATCH;
          nomatch_seen++;
        end else begin
          cancelled += hits;
          if (cancelled >= size / 2) compact();
        end
        batch.push_back(one);
      end else if (r.op == OP_TICK) begin
        while (size > 0 && expiry[0] <= r.now) begin
          if (live[0]) begin
            one = '0;
            one.fired_id = ids[0];
            one.fired = 1'b1;
            if (batch.size() < CAP) batch.push_back(one);
          end else if (cancelled > 0) begin
            cancelled--;
          end
          pop_root();
        end
        if (batch.size() == 0) batch.push_back(tem_rsp_t'('0));
      end else begin
        batch.push_back(one);
      end
      foreach (batch[j]) begin
        batch[j].live_count = size[5:0];
        batch[j].last = (j == batch.size() - 1);
        pending.push_back(batch[j]);
      end
    endfunction

    task check_response(tem_rsp_t got);
      tem_rsp_t want;
      checked++;
      if (got.fired) fired_seen++;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("response with nothing expected: %p", got));
        return;
      end
      want = pending.pop_front();
      if (got.fired_id !== want.fired_id)
        report_mismatch($sformatf("fired_id %h, expected %h", got.fired_id, want.fired_id));
      if (got.fired !== want.fired)
        report_mismatch($sformatf("fired %b, expected %b", got.fired, want.fired));
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %b, expected %b", got.last, want.last));
      if (got.live_count !== want.live_count)
        report_mismatch($sformatf("live_count %0d, expected %0d",
                                  got.live_count, want.live_count));
    endtask

    task report_mismatch(string msg);
      errors++;
      if (errors <= 40) $display("MISMATCH at response %0d: %s", checked, msg);
    endtask
  endclass

  logic     clk;
  logic     rst;
  logic     req_valid;
  logic     req_ready;
  tem_req_t req;
  logic     rsp_valid;
  logic     rsp_ready = 1'b0;
  tem_rsp_t rsp;

  timer_heap_scoreboard board;
  int   cycles = 0;
  bit   stim_done;
  bit   stall_on = 1'b1;
  logic [15:0] used_ids[$];
  logic [31:0] clock_now;

  timer_expiry_min_heap dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Response side: random stalls, with stretches where it is always ready.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) board.check_response(rsp);
      if (!stall_on) rsp_ready <= 1'b1;
      else rsp_ready <= ($urandom_range(0, 99) < 65);
    end
  end

  always @(posedge clk) begin
    if ($urandom_range(0, 299) == 0) stall_on <= ~stall_on;
  end

  // Valid stays high between back-to-back requests and drops only for a gap or after the last request.
  task automatic send_request(logic [1:0] op, logic [15:0] id, logic [31:0] expire_t,
                              logic [31:0] now_t);
    tem_req_t r;
    int gap;
    r.op = op;
    r.timer_id = id;
    r.expire_time = expire_t;
    r.now = now_t;
    gap = stall_on ? pick_gap() : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    board.note_request(r);
  endtask

  task automatic add_timer(logic [15:0] id, logic [31:0] expire_t);
    if (used_ids.size() < 64) used_ids.push_back(id);
    send_request(OP_ADD, id, expire_t, $urandom());
  endtask

  task automatic random_request();
    int roll;
    logic [15:0] id;
    roll = $urandom_range(0, 99);
    if (roll < 45) begin
      if ($urandom_range(0, 3) == 0) id = 16'($urandom());
      else id = 16'($urandom_range(0, 15));
      add_timer(id, clock_now + $urandom_range(0, 400));
    end else if (roll < 65) begin
      if (used_ids.size() > 0 && $urandom_range(0, 4) != 0)
        id = used_ids[$urandom_range(0, used_ids.size() - 1)];
      else id = 16'($urandom());
      send_request(OP_CANCEL, id, $urandom(), $urandom());
    end else if (roll < 95) begin
      clock_now = clock_now + $urandom_range(0, 120);
      send_request(OP_TICK, 16'($urandom()), $urandom(), clock_now);
    end else if (roll < 98) begin
      send_request(OP_UNUSED, 16'($urandom()), $urandom(), $urandom());
    end else begin
      send_request(OP_TICK, 16'($urandom()), $urandom(), 32'hFFFF_FFFF);
    end
  endtask

  initial begin
    board = new();
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    stim_done = 0;
    clock_now = 32'd1000;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: empty tick, no-match cancel, extremes, fill past full, duplicates.
    send_request(OP_TICK, 16'h0, 32'h0, 32'h0);
    send_request(OP_CANCEL, 16'hFFFF, 32'h0, 32'h0);
    add_timer(16'hFFFF, 32'hFFFF_FFFF);
    add_timer(16'h0000, 32'h0000_0000);
    add_timer(16'h5A5A, 32'hA5A5_A5A5);
    add_timer(16'h5A5A, 32'h5A5A_5A5A);
    send_request(OP_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_CANCEL, 16'h5A5A, 32'h0, 32'h0);
    for (int i = 0; i < 31; i++) add_timer(i[15:0], 32'd50 + $urandom_range(0, 100));
    send_request(OP_TICK, 16'h0, 32'h0, 32'd100);
    send_request(OP_TICK, 16'h0, 32'h0, 32'hFFFF_FFFF);

    for (int n = 0; n < 420; n++) random_request();
    send_request(OP_TICK, 16'h0, 32'h0, 32'hFFFF_FFFF);
    req_valid <= 1'b0;
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Checked %0d responses: %0d fired timers, %0d full rejects, %0d empty cancels.",
             board.checked, board.fired_seen, board.full_seen, board.nomatch_seen);
    if (board.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    wait (cycles >= MAX_CYCLES);
    $display("Timeout after %0d cycles with %0d responses outstanding.",
             cycles, board.pending.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
